// File: rtl/tkpt_pkg.sv
// Shared types, constants and a helper function of the timestamp keyed priority table.
package tkpt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Widths of the transfer fields.
  localparam int OP_W     = 3;
  localparam int OWNER_W  = 16;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int KEY_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;

  // year / 25 by reciprocal: exact for every 14 bit year.
  localparam int                 QUOT_W     = 10;
  localparam int                 RECIP_SH   = 20;
  localparam logic [15:0]        RECIP_25   = 16'd41944;
  localparam int                 PROD_W     = YEAR_W + 16;

  localparam logic [HOUR_W-1:0]   MAX_HOUR   = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0] MAX_MINUTE = MINUTE_W'(59);
  localparam logic [MONTH_W-1:0]  MAX_MONTH  = MONTH_W'(12);
  localparam logic [MONTH_W-1:0]  FEBRUARY   = MONTH_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_COUNT_DATE = 3'd1,
    OP_READ_MIN   = 3'd2,
    OP_POP_MIN    = 3'd3,
    OP_DROP_OWNER = 3'd4,
    OP_CLEAR      = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_BAD_DATE = 3'd1,
    STS_BAD_TIME = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_FULL     = 3'd4
  } status_t;

  // Key sits in the low bits so that year..minute compare as one word.
  typedef struct packed {
    logic [OWNER_W-1:0]  owner;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } entry_t;

  typedef struct packed {
    logic date_ok;
    logic time_ok;
  } chk_t;

  typedef struct packed {
    logic less;      // stored key below best key so far
    logic date_eq;   // stored date equals request date
    logic owner_eq;  // stored owner equals request owner
  } cmp_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
      default:                   len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

// File: rtl/tkpt_if.sv
// Request and response channel interfaces of the priority table.
interface tkpt_req_if import tkpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [OWNER_W-1:0]  owner_id;
  logic [DAY_W-1:0]    day;
  logic [MONTH_W-1:0]  month;
  logic [YEAR_W-1:0]   year;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;

  modport source (output valid, opcode, owner_id, day, month, year, hour, minute,
                  input ready);
  modport sink   (input valid, opcode, owner_id, day, month, year, hour, minute,
                  output ready);
endinterface

interface tkpt_rsp_if import tkpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [OWNER_W-1:0]  out_owner_id;
  logic [DAY_W-1:0]    out_day;
  logic [MONTH_W-1:0]  out_month;
  logic [YEAR_W-1:0]   out_year;
  logic [HOUR_W-1:0]   out_hour;
  logic [MINUTE_W-1:0] out_minute;

  modport source (output valid, status, count, out_owner_id, out_day, out_month,
                  out_year, out_hour, out_minute, input ready);
  modport sink   (input valid, status, count, out_owner_id, out_day, out_month,
                  out_year, out_hour, out_minute, output ready);
endinterface

// File: rtl/tkpt_store.sv
// Entry memory: one write port, one read port with registered read data.
module tkpt_store import tkpt_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tkpt_date_chk.sv
// Gregorian date and 24-hour time check of the held request.
module tkpt_date_chk import tkpt_pkg::*; (
  input  logic   clk,
  input  entry_t req,
  output chk_t   chk
);

  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;    // year / 25, registered from req.year
  logic [YEAR_W:0]     back;
  logic                div25;
  logic                leap;
  logic [DAY_W-1:0]    lim;

  assign prod = req.year * RECIP_25;

  always_ff @(posedge clk) begin
    quot <= prod[RECIP_SH +: QUOT_W];
  end

  // 100 | y  <=>  4 | y and 25 | y;  400 | y  <=>  16 | y and 25 | y
  assign back  = (YEAR_W + 1)'(quot) * (YEAR_W + 1)'(25);
  assign div25 = (back == {1'b0, req.year});
  assign leap  = (req.year[1:0] == 2'b00) && (!div25 || (req.year[3:0] == 4'b0000));
  assign lim   = month_len(req.month, leap);

  assign chk.date_ok = (req.year != '0) && (req.month != '0) && (req.month <= MAX_MONTH) &&
                       (req.day != '0) && (req.day <= lim);
  assign chk.time_ok = (req.hour <= MAX_HOUR) && (req.minute <= MAX_MINUTE);

endmodule

// File: rtl/tkpt_cmp.sv
// Shared compare unit applied to each entry as it streams out of the store.
module tkpt_cmp import tkpt_pkg::*; (
  input  entry_t           cur,
  input  logic [KEY_W-1:0] best_key,
  input  entry_t           req,
  output cmp_t             res
);

  assign res.less     = (cur[KEY_W-1:0] < best_key);
  assign res.date_eq  = (cur.year == req.year) && (cur.month == req.month) &&
                        (cur.day == req.day);
  assign res.owner_eq = (cur.owner == req.owner);

endmodule

// File: rtl/timestamp_keyed_priority_table.sv
// Top level: sequencer driving the entry store, date check and shared compare unit.
// Insert, clear, unused codes, a bad date and read/remove on an empty table go from S_DIV
//   and S_EVAL straight to S_RESP; count, read earliest and remove owner add one pass over
//   the held entries in S_SCAN, and remove earliest adds two. A stalled response adds its wait.
// Throughput: one operation at a time; the next transfer lands the cycle after the response loads.
// Reset (synchronous, rst high) empties the table; store contents are not cleared.
module timestamp_keyed_priority_table import tkpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tkpt_req_if.sink   req,
  tkpt_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a request transfer
    S_DIV,    // year / 25 settles in the date checker
    S_EVAL,   // decide: finish now or start a pass over the store
    S_SCAN,   // stream entries through the compare unit
    S_RESP    // hand result to the output register
  } state_t;

  state_t              state;
  opcode_t             op;
  entry_t              req_e;
  logic [CNT_W-1:0]    count;     // entries held
  logic [CNT_W-1:0]    rd;        // next read position
  logic [CNT_W-1:0]    wr;        // next write position while compacting
  logic [CNT_W-1:0]    tally;     // date matches
  logic [IDX_W-1:0]    rd_idx;    // position of the entry in rdata
  logic                d_vld;     // rdata holds a fresh entry
  logic                compact;   // second kind of pass: rewrite kept entries
  logic [IDX_W-1:0]    best_pos;
  entry_t              best;

  // Result waiting for the output register
  status_t             res_status;
  logic [CNT_W-1:0]    res_count;
  entry_t              res_hit;

  // Output register
  logic                out_valid;
  status_t             out_status;
  logic [CNT_W-1:0]    out_count;
  entry_t              out_hit;

  chk_t                chk;
  cmp_t                cmp;
  entry_t              rdata;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;
  logic                re;
  logic                keep;
  logic                ins_ok;
  logic                scan_done;

  assign req.ready = (state == S_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.count        = COUNT_W'(out_count);
  assign rsp.out_owner_id = out_hit.owner;
  assign rsp.out_day      = out_hit.day;
  assign rsp.out_month    = out_hit.month;
  assign rsp.out_year     = out_hit.year;
  assign rsp.out_hour     = out_hit.hour;
  assign rsp.out_minute   = out_hit.minute;

  tkpt_date_chk u_chk (
    .clk (clk),
    .req (req_e),
    .chk (chk)
  );

  tkpt_cmp u_cmp (
    .cur      (rdata),
    .best_key (best[KEY_W-1:0]),
    .req      (req_e),
    .res      (cmp)
  );

  // Insert goes in at the tail; compaction writes kept entries at wr,
  // which never passes the read position.
  assign ins_ok = (state == S_EVAL) && (op == OP_INSERT) && chk.date_ok && chk.time_ok &&
                  (count != CNT_W'(CAPACITY));
  assign keep   = !(((op == OP_DROP_OWNER) && cmp.owner_eq) ||
                    ((op == OP_POP_MIN) && (rd_idx == best_pos)));
  assign we     = ins_ok || ((state == S_SCAN) && compact && d_vld && keep);
  assign waddr  = (state == S_EVAL) ? count[IDX_W-1:0] : wr[IDX_W-1:0];
  assign wdata  = (state == S_EVAL) ? req_e : rdata;
  assign re     = (state == S_SCAN) && (rd < count);

  assign scan_done = (state == S_SCAN) && !re && !d_vld;

  tkpt_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      d_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      d_vld  <= re;
      rd_idx <= rd[IDX_W-1:0];
      if (re) begin
        rd <= rd + 1'b1;
      end
      // S_RESP reloads the register itself
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op           <= opcode_t'(req.opcode);
            req_e.owner  <= req.owner_id;
            req_e.year   <= req.year;
            req_e.month  <= req.month;
            req_e.day    <= req.day;
            req_e.hour   <= req.hour;
            req_e.minute <= req.minute;
            state        <= S_DIV;
          end
        end

        S_DIV: begin
          state <= S_EVAL;
        end

        S_EVAL: begin
          res_hit <= '0;
          rd      <= '0;
          wr      <= '0;
          tally   <= '0;
          compact <= (op == OP_DROP_OWNER);
          unique case (op)
            OP_INSERT: begin
              state     <= S_RESP;
              res_count <= ins_ok ? count + 1'b1 : count;
              if (ins_ok) begin
                count <= count + 1'b1;
              end
              priority if (!chk.date_ok) begin
                res_status <= STS_BAD_DATE;
              end else if (!chk.time_ok) begin
                res_status <= STS_BAD_TIME;
              end else if (count == CNT_W'(CAPACITY)) begin
                res_status <= STS_FULL;
              end else begin
                res_status <= STS_OK;
              end
            end
            OP_COUNT_DATE: begin
              res_count <= count;
              if (!chk.date_ok) begin
                res_status <= STS_BAD_DATE;
                state      <= S_RESP;
              end else begin
                res_status <= STS_OK;
                state      <= S_SCAN;
              end
            end
            OP_READ_MIN, OP_POP_MIN: begin
              res_count <= count;
              if (count == '0) begin
                res_status <= STS_EMPTY;
                state      <= S_RESP;
              end else begin
                res_status <= STS_OK;
                state      <= S_SCAN;
              end
            end
            OP_DROP_OWNER: begin
              res_status <= STS_OK;
              res_count  <= count;
              state      <= S_SCAN;
            end
            OP_CLEAR: begin
              res_status <= STS_OK;
              count      <= '0;
              res_count  <= '0;
              state      <= S_RESP;
            end
            default: begin  // unused codes leave the table alone
              res_status <= STS_OK;
              res_count  <= count;
              state      <= S_RESP;
            end
          endcase
        end

        S_SCAN: begin
          if (d_vld) begin
            if (compact) begin
              if (keep) begin
                wr <= wr + 1'b1;
              end
            end else begin
              if (cmp.date_eq) begin
                tally <= tally + 1'b1;
              end
              // strict less keeps the older entry on a tie
              if ((rd_idx == '0) || cmp.less) begin
                best     <= rdata;
                best_pos <= rd_idx;
              end
            end
          end
          if (scan_done) begin
            priority if ((op == OP_POP_MIN) && !compact) begin
              // second pass closes the gap left by the earliest entry
              compact <= 1'b1;
              rd      <= '0;
              wr      <= '0;
            end else begin
              state <= S_RESP;
              priority if (op == OP_COUNT_DATE) begin
                res_count <= tally;
              end else if (op == OP_READ_MIN) begin
                res_hit <= best;
              end else if (op == OP_POP_MIN) begin
                count     <= wr;
                res_count <= wr;
                res_hit   <= best;
              end else begin
                count     <= wr;
                res_count <= count - wr;
              end
            end
          end
        end

        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= res_count;
            out_hit    <= res_hit;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Table never overfills.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Compaction write never overtakes the read stream.
  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && compact |-> wr <= rd)
    else $error("compaction write ahead of read");

  // Entry fields are shown only on a successful read or removal.
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != STS_OK) |-> (out_hit == '0))
    else $error("entry fields set on failed operation");

  // A clear empties the table once evaluated.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.opcode == OP_CLEAR) |-> ##3 (count == '0))
    else $error("clear left entries in the table");

endmodule
